/* rtl/core/pwk_pkg.sv */
// ----------------------------------------------------------------------------
// pwk_pkg
// Shared types and constants for the four-level page walker.
// ----------------------------------------------------------------------------
package pwk_pkg;

	localparam int TOP_ENTRIES_C = 512;
	localparam int IDX_W         = 9;
	localparam int CFG_AW        = 3;

	localparam int PML4SHIFT = 39;
	localparam int PDPSHIFT  = 30;
	localparam int PDRSHIFT  = 21;
	localparam int PT_SHIFT  = 12;

	localparam int PG_V  = 0;
	localparam int PG_PS = 7;

	localparam logic [63:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;
	localparam logic [21:0] NBPDR      = 22'h20_0000;
	localparam logic [21:0] PAGE_BYTES = 22'h00_1000;
	localparam logic [63:0] LARGE_MASK = ~(64'(NBPDR) - 64'd1);

	localparam logic [1:0] CMD_TRANSLATE = 2'd0;
	localparam logic [1:0] CMD_RESPONSE  = 2'd1;
	localparam logic [1:0] CMD_LOAD      = 2'd2;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [CFG_AW-3:0] REG_TRANSLATE_ENABLE = '0;

	typedef enum logic [1:0] {
		LVL_IDLE,
		LVL_PDP,
		LVL_PD,
		LVL_PT
	} walk_lvl_t;

	typedef struct packed {
		logic [1:0]       cmd;
		logic [63:0]      vaddr;
		logic [63:0]      entry_data;
		logic             read_ok;
		logic [IDX_W-1:0] top_index;
	} in_item_t;

	typedef struct packed {
		logic        result_kind;
		logic [51:0] read_addr;
		logic [63:0] phys_addr;
		logic [21:0] bytes_left;
		logic        valid_res;
	} out_item_t;

	typedef struct packed {
		logic step;
		logic adv;
	} walk_ctl_t;

endpackage

/* rtl/core/pwk_ram.sv */
// ----------------------------------------------------------------------------
// pwk_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pwk_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* rtl/core/pwk_apb.sv */
// ----------------------------------------------------------------------------
// pwk_apb
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module pwk_apb
	import pwk_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output logic              translate_enable
);

	logic en_q;
	logic hit;

	assign hit              = (paddr[CFG_AW-1:2] == REG_TRANSLATE_ENABLE);
	assign pready           = 1'b1;
	assign translate_enable = en_q;
	assign prdata           = hit ? {31'd0, en_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && hit) begin
			en_q <= pwdata[0];
		end
	end

endmodule

/* rtl/core/pwk_walk.sv */
// ----------------------------------------------------------------------------
// pwk_walk
// Walk sequencer: decodes the request and table entry, keeps the walk
// level and saved address, and holds the result register.
// ----------------------------------------------------------------------------
module pwk_walk
	import pwk_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_s1,
	input  in_item_t  item_s1,
	input  logic [63:0] top_entry,
	input  logic      translate_enable,
	output walk_ctl_t ctl,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	walk_lvl_t   lvl_q, lvl_d;
	logic [63:0] saved_q, saved_d;
	logic        out_valid_q;
	out_item_t   out_q;
	out_item_t   res;
	logic        res_gen;
	logic [63:0] ent;

	assign ctl.adv   = !out_valid_q || out_ready;
	assign ctl.step  = valid_s1 && ctl.adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign ent       = item_s1.entry_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q   <= LVL_IDLE;
			saved_q <= '0;
		end else if (ctl.step) begin
			lvl_q   <= lvl_d;
			saved_q <= saved_d;
		end
	end

	always_comb begin
		lvl_d   = lvl_q;
		saved_d = saved_q;
		res_gen = 1'b0;
		res     = '0;
		unique case (item_s1.cmd)
			CMD_TRANSLATE: begin
				lvl_d   = LVL_IDLE;
				res_gen = 1'b1;
				if (!translate_enable) begin
					res.result_kind = KIND_DONE;
					res.phys_addr   = item_s1.vaddr;
					res.bytes_left  = PAGE_BYTES - 22'(item_s1.vaddr[PT_SHIFT-1:0]);
					res.valid_res   = 1'b1;
				end else begin
					saved_d = item_s1.vaddr;
					if (!top_entry[PG_V]) begin
						res.result_kind = KIND_DONE;
					end else begin
						lvl_d           = LVL_PDP;
						res.result_kind = KIND_READ;
						res.read_addr   = 52'(top_entry & FRAME_MASK)
							| 52'({item_s1.vaddr[PDPSHIFT +: IDX_W], 3'b000});
					end
				end
			end
			CMD_RESPONSE: begin
				if (lvl_q != LVL_IDLE) begin
					res_gen = 1'b1;
					if (!item_s1.read_ok || !ent[PG_V]) begin
						lvl_d           = LVL_IDLE;
						res.result_kind = KIND_DONE;
					end else begin
						unique case (lvl_q)
							LVL_PDP: begin
								lvl_d           = LVL_PD;
								res.result_kind = KIND_READ;
								res.read_addr   = 52'(ent & FRAME_MASK)
									| 52'({saved_q[PDRSHIFT +: IDX_W], 3'b000});
							end
							LVL_PD: begin
								if (ent[PG_PS]) begin
									lvl_d           = LVL_IDLE;
									res.result_kind = KIND_DONE;
									res.phys_addr   = (ent & FRAME_MASK & LARGE_MASK)
										| 64'(saved_q[PDRSHIFT-1:0]);
									res.bytes_left  = NBPDR - 22'(saved_q[PDRSHIFT-1:0]);
									res.valid_res   = 1'b1;
								end else begin
									lvl_d           = LVL_PT;
									res.result_kind = KIND_READ;
									res.read_addr   = 52'(ent & FRAME_MASK)
										| 52'({saved_q[PT_SHIFT +: IDX_W], 3'b000});
								end
							end
							LVL_PT: begin
								lvl_d           = LVL_IDLE;
								res.result_kind = KIND_DONE;
								res.phys_addr   = (ent & FRAME_MASK)
									| 64'(saved_q[PT_SHIFT-1:0]);
								res.bytes_left  = PAGE_BYTES - 22'(saved_q[PT_SHIFT-1:0]);
								res.valid_res   = 1'b1;
							end
							default: begin
								lvl_d   = LVL_IDLE;
								res_gen = 1'b0;
							end
						endcase
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.adv) begin
			out_valid_q <= ctl.step && res_gen;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && res_gen) begin
			out_q <= res;
		end
	end

endmodule

/* rtl/core/four_level_page_walker_core.sv */
// ----------------------------------------------------------------------------
// four_level_page_walker_core
// Four-level page table walker with an on-chip top-level table. Issues
// read requests for lower levels and returns the translated address.
//
//   channel  dir  handshake              contents
//   in       in   in_valid / in_ready    translate, read response, top load
//   out      out  out_valid / out_ready  read request or finished walk
//   cfg      in   psel/penable/pwrite    translate_enable at address 0
//
// One request per cycle while out is not stalled. An accepted request is registered
// into stage 1 while the top table RAM is read; stage 1 then decodes and loads the result
// register. A stall on out holds the result and stage 1, and in_ready drops once stage 1 is full.
// Reset clears control state only; top table slots are undefined until
// loaded, and there is no clearing pass.
// ----------------------------------------------------------------------------
module four_level_page_walker_core
	import pwk_pkg::*;
#(
	parameter int TOP_ENTRIES = TOP_ENTRIES_C
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int TOP_AW = $clog2(TOP_ENTRIES);

	logic              valid_s1;
	in_item_t          item_s1;
	logic              in_acc;
	logic              ram_we;
	logic              ram_re;
	logic [TOP_AW-1:0] ram_addr;
	logic [63:0]       top_entry;
	logic              translate_enable;
	walk_ctl_t         ctl;

	assign in_ready = !valid_s1 || ctl.adv;
	assign in_acc   = in_valid && in_ready;
	assign ram_we   = in_acc && (in_data.cmd == CMD_LOAD);
	assign ram_re   = in_acc && (in_data.cmd == CMD_TRANSLATE);
	assign ram_addr = ram_we ? in_data.top_index[TOP_AW-1:0]
		: in_data.vaddr[PML4SHIFT +: TOP_AW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (ctl.adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= in_data;
		end
	end

	pwk_ram #(
		.WIDTH(64),
		.DEPTH(TOP_ENTRIES)
	) u_top_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (ram_addr),
		.wdata(in_data.entry_data),
		.rdata(top_entry)
	);

	pwk_apb u_apb (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.translate_enable(translate_enable)
	);

	pwk_walk u_walk (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s1        (valid_s1),
		.item_s1         (item_s1),
		.top_entry       (top_entry),
		.translate_enable(translate_enable),
		.ctl             (ctl),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data)
	);

	a_ready_only_blocked_by_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1)
		else $error("in_ready low with empty stage 1");

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == KIND_DONE && !out_data.valid_res
		|-> out_data.bytes_left == 22'd0 && out_data.phys_addr == 64'd0)
		else $error("invalid walk with nonzero address or size");

	a_valid_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.result_kind == KIND_DONE && out_data.valid_res
		|-> out_data.bytes_left != 22'd0)
		else $error("successful walk with zero bytes left");

	a_ram_single_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("top table read and write in one cycle");

endmodule

/* tb/four_level_page_walker_core_tb.sv */
// ----------------------------------------------------------------------------
// four_level_page_walker_core_tb
// Self-checking bench for the four-level page walker. A short table of
// directed requests covers reset state, address extremes, non-present and
// failed reads, large pages, abandoned walks and enable changes mid-walk.
// Random phases then alternate the translate enable and mix table loads,
// full walks with random entries, broken walks and ignored requests. Each result
// is compared field by field against a directed row or an in-bench walk predictor.
// ----------------------------------------------------------------------------
module four_level_page_walker_core_tb;
	import pwk_pkg::*;

	localparam logic [1:0]        CMD_UNUSED     = 2'd3;
	localparam logic [CFG_AW-1:0] EN_ADDR        = {REG_TRANSLATE_ENABLE, 2'b00};
	localparam logic [63:0]       ONES64         = '1;
	localparam logic [63:0]       TOP0_ENTRY     = 64'h0000_0000_0010_0003;
	localparam logic [63:0]       VA_MID         = 64'h0000_0000_4020_3ABC;
	localparam logic [63:0]       VA_SLOT1       = 64'h0000_0080_0000_0000;
	localparam int                RAND_ITEMS     = 360;
	localparam int                PHASE_ITEMS    = 40;
	localparam int                LONG_HOLD      = 200;
	localparam int                WATCHDOG_LIMIT = 2000;

	typedef struct {
		bit        is_cfg;
		logic      cfg_val;
		in_item_t  req;
		bit        typed;
		out_item_t res;
	} dir_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [CFG_AW-1:0] paddr = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	bit          req_typed     = 1'b0;
	out_item_t   req_typed_res = '0;

	logic [63:0] top_copy [TOP_ENTRIES_C];
	walk_lvl_t   lvl_copy = LVL_IDLE;
	logic [63:0] va_copy  = '0;
	logic        en_copy  = 1'b0;

	out_item_t   pending_results [$];
	dir_row_t    dir_rows [$];
	bit          slot_used [TOP_ENTRIES_C];
	logic [8:0]  used_slots [$];
	bit          no_gaps   = 1'b0;
	bit          long_hold = 1'b0;
	int          errors    = 0;
	int          idle_cycles = 0;

	four_level_page_walker_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #4 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic in_item_t mk_req(input logic [1:0] cmd, input logic [63:0] va,
		input logic [63:0] data, input logic ok, input logic [8:0] slot);
		in_item_t r;
		r.cmd        = cmd;
		r.vaddr      = va;
		r.entry_data = data;
		r.read_ok    = ok;
		r.top_index  = slot;
		return r;
	endfunction

	function automatic out_item_t done_res(input logic [63:0] pa, input logic [21:0] bytes,
		input logic ok);
		out_item_t r;
		r             = '0;
		r.result_kind = KIND_DONE;
		r.phys_addr   = ok ? pa : '0;
		r.bytes_left  = ok ? bytes : '0;
		r.valid_res   = ok;
		return r;
	endfunction

	function automatic out_item_t read_res(input logic [63:0] entry, input int shift);
		out_item_t   r;
		logic [8:0]  idx;
		logic [63:0] addr;
		idx           = va_copy[shift +: IDX_W];
		addr          = (entry & FRAME_MASK) + {52'd0, idx, 3'b000};
		r             = '0;
		r.result_kind = KIND_READ;
		r.read_addr   = addr[51:0];
		return r;
	endfunction

	// walk state follows every accepted request
	function automatic bit predict_walk(input in_item_t it, output out_item_t res);
		logic [63:0] top;
		logic [63:0] data;
		res  = '0;
		data = it.entry_data;
		case (it.cmd)
			CMD_LOAD: begin
				top_copy[it.top_index] = data;
				return 1'b0;
			end
			CMD_TRANSLATE: begin
				lvl_copy = LVL_IDLE;
				if (!en_copy) begin
					res = done_res(it.vaddr, PAGE_BYTES - {10'd0, it.vaddr[11:0]}, 1'b1);
					return 1'b1;
				end
				va_copy = it.vaddr;
				top     = top_copy[it.vaddr[PML4SHIFT +: IDX_W]];
				if (!top[PG_V]) begin
					res = done_res('0, '0, 1'b0);
					return 1'b1;
				end
				lvl_copy = LVL_PDP;
				res      = read_res(top, PDPSHIFT);
				return 1'b1;
			end
			CMD_RESPONSE: begin
				if (lvl_copy == LVL_IDLE)
					return 1'b0;
				if (!it.read_ok || !data[PG_V]) begin
					lvl_copy = LVL_IDLE;
					res      = done_res('0, '0, 1'b0);
					return 1'b1;
				end
				case (lvl_copy)
					LVL_PDP: begin
						lvl_copy = LVL_PD;
						res      = read_res(data, PDRSHIFT);
					end
					LVL_PD: begin
						if (data[PG_PS]) begin
							lvl_copy = LVL_IDLE;
							res = done_res((data & FRAME_MASK & LARGE_MASK)
								+ {43'd0, va_copy[20:0]},
								NBPDR - {1'b0, va_copy[20:0]}, 1'b1);
						end else begin
							lvl_copy = LVL_PT;
							res      = read_res(data, PT_SHIFT);
						end
					end
					default: begin
						lvl_copy = LVL_IDLE;
						res = done_res((data & FRAME_MASK) + {52'd0, va_copy[11:0]},
							PAGE_BYTES - {10'd0, va_copy[11:0]}, 1'b1);
					end
				endcase
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// top index always points at a loaded slot
	function automatic logic [63:0] legal_va();
		logic [63:0] va;
		va = rand64();
		if (!slot_used[va[PML4SHIFT +: IDX_W]])
			va[PML4SHIFT +: IDX_W] = used_slots[$urandom_range(0, used_slots.size() - 1)];
		return va;
	endfunction

	function automatic void mark_slot(input logic [8:0] slot);
		if (!slot_used[slot]) begin
			slot_used[slot] = 1'b1;
			used_slots.push_back(slot);
		end
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
		end
	endtask

	task automatic send_req(input in_item_t it, input bit typed, input out_item_t res);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		in_data       <= it;
		req_typed     <= typed;
		req_typed_res <= res;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic val);
		logic [31:0] rd;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= EN_ADDR;
		pwdata  <= {31'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		en_copy = val;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd !== {31'd0, val}) begin
			errors++;
			$display("%0t enable readback mismatch: expected %h actual %h", $time,
				{31'd0, val}, rd);
		end
	endtask

	always @(posedge clk) begin : result_check
		out_item_t pred;
		out_item_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (predict_walk(in_data, pred))
					pending_results.push_back(req_typed ? req_typed_res : pred);
			end
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none actual %h", $time,
						out_data);
				end else begin
					want = pending_results.pop_front();
					check_field("result_kind", 64'(want.result_kind),
						64'(out_data.result_kind));
					check_field("read_addr", 64'(want.read_addr), 64'(out_data.read_addr));
					check_field("phys_addr", want.phys_addr, out_data.phys_addr);
					check_field("bytes_left", 64'(want.bytes_left), 64'(out_data.bytes_left));
					check_field("valid_res", 64'(want.valid_res), 64'(out_data.valid_res));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin : result_sink
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 17);
			if (long_hold) begin
				stall     = LONG_HOLD;
				long_hold = 1'b0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		int          r;
		int          n;
		int          ph;
		int          sent;
		logic        en_phase;
		logic [63:0] d;
		logic [8:0]  s;
		bit          big_pg;
		bit          ok;

		// slot loads, then reset state with translation off
		dir_rows.push_back('{0, 0, mk_req(CMD_LOAD, '0, ONES64, 1'b1, 9'd511), 0, '0});
		dir_rows.push_back('{0, 0, mk_req(CMD_LOAD, '0, TOP0_ENTRY, 1'b0, 9'd0), 0, '0});
		dir_rows.push_back('{0, 0, mk_req(CMD_LOAD, '0, '0, 1'b0, 9'd1), 0, '0});
		dir_rows.push_back('{0, 0, mk_req(CMD_TRANSLATE, '0, '0, 1'b0, '0), 1,
			done_res('0, PAGE_BYTES, 1'b1)});
		dir_rows.push_back('{0, 0, mk_req(CMD_TRANSLATE, ONES64, ONES64, 1'b1, 9'd511), 1,
			done_res(ONES64, 22'd1, 1'b1)});
		dir_rows.push_back('{0, 0, mk_req(CMD_RESPONSE, ONES64, ONES64, 1'b1, 9'd511), 0, '0});
		dir_rows.push_back('{0, 0, mk_req(CMD_UNUSED, ONES64, ONES64, 1'b1, 9'd511), 0, '0});
		dir_rows.push_back('{1, 1, '0, 0, '0});
		// non-present top slot and failed read
		dir_rows.push_back('{0, 0, mk_req(CMD_TRANSLATE, VA_SLOT1, '0, 1'b1, '0), 1,
			done_res('0, '0, 1'b0)});
		dir_rows.push_back('{0, 0, mk_req(CMD_TRANSLATE, VA_MID, '0, 1'b1, '0), 0, '0});
		dir_rows.push_back('{0, 0, mk_req(CMD_RESPONSE, VA_MID, ONES64, 1'b0, '0), 1,
			done_res('0, '0, 1'b0)});
		// large page at the top of the address space
		dir_rows.push_back('{0, 0, mk_req(CMD_TRANSLATE, ONES64, '0, 1'b1, '0), 0, '0});
		dir_rows.push_back('{0, 0, mk_req(CMD_RESPONSE, '0, ONES64, 1'b1, '0), 0, '0});
		dir_rows.push_back('{0, 0, mk_req(CMD_RESPONSE, '0, ONES64, 1'b1, '0), 0, '0});
		// full four-level walk
		dir_rows.push_back('{0, 0, mk_req(CMD_TRANSLATE, VA_MID, '0, 1'b1, '0), 0, '0});
		dir_rows.push_back('{0, 0, mk_req(CMD_RESPONSE, '0, 64'h20_0001, 1'b1, '0), 0, '0});
		dir_rows.push_back('{0, 0, mk_req(CMD_RESPONSE, '0, 64'h30_0001, 1'b1, '0), 0, '0});
		dir_rows.push_back('{0, 0, mk_req(CMD_RESPONSE, '0, ONES64, 1'b1, '0), 0, '0});
		// abandoned walk, then entry with valid bit clear
		dir_rows.push_back('{0, 0, mk_req(CMD_TRANSLATE, VA_MID, '0, 1'b1, '0), 0, '0});
		dir_rows.push_back('{0, 0, mk_req(CMD_TRANSLATE, '0, '0, 1'b1, '0), 0, '0});
		dir_rows.push_back('{0, 0, mk_req(CMD_RESPONSE, '0, ~64'd1, 1'b1, '0), 1,
			done_res('0, '0, 1'b0)});
		dir_rows.push_back('{0, 0, mk_req(CMD_RESPONSE, '0, ONES64, 1'b1, '0), 0, '0});
		// largest byte count
		dir_rows.push_back('{0, 0, mk_req(CMD_TRANSLATE, '0, '0, 1'b1, '0), 0, '0});
		dir_rows.push_back('{0, 0, mk_req(CMD_RESPONSE, '0, 64'h1, 1'b1, '0), 0, '0});
		dir_rows.push_back('{0, 0, mk_req(CMD_RESPONSE, '0, 64'h81, 1'b1, '0), 1,
			done_res('0, NBPDR, 1'b1)});
		// enable dropped with a walk in flight
		dir_rows.push_back('{0, 0, mk_req(CMD_TRANSLATE, ONES64, '0, 1'b1, '0), 0, '0});
		dir_rows.push_back('{1, 0, '0, 0, '0});
		dir_rows.push_back('{0, 0, mk_req(CMD_RESPONSE, '0, 64'h40_0001, 1'b1, '0), 0, '0});

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[k]) begin
			if (dir_rows[k].is_cfg) begin
				drain();
				cfg_write(dir_rows[k].cfg_val);
			end else begin
				send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].res);
				if (dir_rows[k].req.cmd == CMD_LOAD)
					mark_slot(dir_rows[k].req.top_index);
			end
		end

		ph   = 0;
		sent = 0;
		while (sent < RAND_ITEMS) begin
			en_phase = ~ph[0];
			drain();
			cfg_write(en_phase);
			if (ph == 1) begin
				long_hold = 1'b1;
				no_gaps   = 1'b1;
			end
			n = 0;
			while (n < PHASE_ITEMS) begin
				if (ph != 1 && $urandom_range(0, 15) == 0)
					no_gaps = ($urandom_range(0, 2) == 0);
				r = $urandom_range(0, 99);
				if (r < 10) begin
					s = 9'($urandom);
					d = rand64();
					d[PG_V] = ($urandom_range(0, 6) != 0);
					send_req(mk_req(CMD_LOAD, legal_va(), d, 1'($urandom), s), 1'b0, '0);
					mark_slot(s);
					n++;
				end else if (r < 75) begin
					send_req(mk_req(CMD_TRANSLATE, legal_va(), rand64(), 1'($urandom),
						9'($urandom)), 1'b0, '0);
					n++;
					if (en_phase) begin
						for (int i = 0; i < 3; i++) begin
							big_pg = (i == 1) && ($urandom_range(0, 2) == 0);
							d = rand64();
							d[PG_V] = ($urandom_range(0, 15) != 0);
							if (i == 1)
								d[PG_PS] = big_pg;
							ok = ($urandom_range(0, 24) != 0);
							send_req(mk_req(CMD_RESPONSE, legal_va(), d, ok, 9'($urandom)),
								1'b0, '0);
							n++;
							if (!ok || !d[PG_V] || big_pg)
								break;
						end
					end
				end else if (r < 88) begin
					// unused command or a stray response, ignored only when no walk is pending
					send_req(mk_req($urandom_range(0, 1) ? CMD_UNUSED : CMD_RESPONSE,
						legal_va(), rand64(), 1'($urandom), 9'($urandom)), 1'b0, '0);
					n++;
				end else begin
					send_req(mk_req(CMD_TRANSLATE, legal_va(), rand64(), 1'($urandom),
						9'($urandom)), 1'b0, '0);
					n++;
					repeat ($urandom_range(0, 2)) begin
						d = rand64();
						d[PG_V]  = 1'b1;
						d[PG_PS] = 1'b0;
						send_req(mk_req(CMD_RESPONSE, legal_va(), d, 1'b1, 9'($urandom)),
							1'b0, '0);
						n++;
					end
				end
			end
			sent += n;
			ph++;
		end

		drain();
		repeat (4) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/pwk_pkg.sv
rtl/core/pwk_ram.sv
rtl/core/pwk_apb.sv
rtl/core/pwk_walk.sv
rtl/core/four_level_page_walker_core.sv
tb/four_level_page_walker_core_tb.sv
